FILE: sv/dbpc_pkg.sv
`timescale 1ns / 1ps

package dbpc_pkg;

    // Button phase codes
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESSED = 2'd1,
        PH_LONG    = 2'd2
    } phase_t;

    // Event codes carried with each result item
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_FACTORY = 2'd1,
        EV_SHORT   = 2'd2,
        EV_LONG    = 2'd3
    } event_t;

    // Configuration register indexes
    localparam int          CFG_IDX_W          = 2;
    localparam logic [1:0]  REG_RESET_LONG     = 2'd0;
    localparam logic [1:0]  REG_ACTION_LONG    = 2'd1;
    localparam logic [1:0]  REG_ACTION_ENABLE  = 2'd2;

    localparam int          THR_W              = 16;
    localparam int          CFG_DATA_W         = 16;

    localparam logic [THR_W-1:0] RESET_LONG_DEFAULT  = 16'd50;
    localparam logic [THR_W-1:0] ACTION_LONG_DEFAULT = 16'd30;

    // Live configuration handed to the step logic
    typedef struct packed {
        logic [THR_W-1:0] reset_long_ticks;
        logic [THR_W-1:0] action_long_ticks;
        logic             action_enable;
    } cfg_t;

endpackage

FILE: sv/dbpc_cfg.sv
`timescale 1ns / 1ps

module dbpc_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dbpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output dbpc_pkg::cfg_t                      cfg
);

    dbpc_pkg::cfg_t cfg_reg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_long_ticks  <= dbpc_pkg::RESET_LONG_DEFAULT;
            cfg_reg.action_long_ticks <= dbpc_pkg::ACTION_LONG_DEFAULT;
            cfg_reg.action_enable     <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dbpc_pkg::REG_RESET_LONG: begin
                    cfg_reg.reset_long_ticks <= cfg_wdata[dbpc_pkg::THR_W-1:0];
                end
                dbpc_pkg::REG_ACTION_LONG: begin
                    cfg_reg.action_long_ticks <= cfg_wdata[dbpc_pkg::THR_W-1:0];
                end
                dbpc_pkg::REG_ACTION_ENABLE: begin
                    cfg_reg.action_enable <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/dbpc_step.sv
`timescale 1ns / 1ps

module dbpc_step #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  dbpc_pkg::cfg_t                  cfg,
    input  logic                            reset_down,
    input  logic                            action_down,
    input  dbpc_pkg::phase_t                reset_phase,
    input  logic [TICK_COUNT_WIDTH-1:0]     reset_ticks,
    input  dbpc_pkg::phase_t                action_phase,
    input  logic [TICK_COUNT_WIDTH-1:0]     action_ticks,
    input  logic                            led_state,
    input  logic                            fast_state,
    output dbpc_pkg::phase_t                reset_phase_next,
    output logic [TICK_COUNT_WIDTH-1:0]     reset_ticks_next,
    output dbpc_pkg::phase_t                action_phase_next,
    output logic [TICK_COUNT_WIDTH-1:0]     action_ticks_next,
    output logic                            led_state_next,
    output logic                            fast_state_next,
    output dbpc_pkg::event_t                event_next
);

    // Common width for counter against threshold
    localparam int CMP_W = (TICK_COUNT_WIDTH > dbpc_pkg::THR_W) ?
                           TICK_COUNT_WIDTH : dbpc_pkg::THR_W;

    logic [TICK_COUNT_WIDTH-1:0] reset_inc;
    logic [TICK_COUNT_WIDTH-1:0] action_inc;
    logic                        reset_over;
    logic                        action_over;

    // Increment both counters and compare against their thresholds
    assign reset_inc   = reset_ticks + TICK_COUNT_WIDTH'(1);
    assign action_inc  = action_ticks + TICK_COUNT_WIDTH'(1);
    assign reset_over  = CMP_W'(reset_inc) > CMP_W'(cfg.reset_long_ticks);
    assign action_over = CMP_W'(action_inc) > CMP_W'(cfg.action_long_ticks);

    // Reset button first, then action button against the updated reset phase
    always_comb begin
        reset_phase_next  = reset_phase;
        reset_ticks_next  = reset_ticks;
        action_phase_next = action_phase;
        action_ticks_next = action_ticks;
        led_state_next    = led_state;
        fast_state_next   = fast_state;
        event_next        = dbpc_pkg::EV_NONE;

        if (!(cfg.action_enable && action_phase != dbpc_pkg::PH_IDLE)) begin
            if (reset_down) begin
                if (reset_phase == dbpc_pkg::PH_IDLE) begin
                    reset_phase_next = dbpc_pkg::PH_PRESSED;
                    reset_ticks_next = '0;
                    fast_state_next  = 1'b1;
                end else begin
                    reset_ticks_next = reset_inc;
                    if (reset_over || reset_phase == dbpc_pkg::PH_LONG) begin
                        reset_phase_next = dbpc_pkg::PH_LONG;
                        led_state_next   = ~reset_inc[0];
                    end
                end
            end else begin
                unique case (reset_phase)
                    dbpc_pkg::PH_PRESSED: begin
                        reset_phase_next = dbpc_pkg::PH_IDLE;
                        reset_ticks_next = '0;
                        led_state_next   = 1'b1;
                        fast_state_next  = 1'b0;
                    end
                    dbpc_pkg::PH_LONG: begin
                        event_next       = dbpc_pkg::EV_FACTORY;
                        reset_phase_next = dbpc_pkg::PH_IDLE;
                        reset_ticks_next = '0;
                        led_state_next   = 1'b0;
                        fast_state_next  = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (cfg.action_enable && reset_phase_next == dbpc_pkg::PH_IDLE) begin
            if (action_down) begin
                if (action_phase == dbpc_pkg::PH_IDLE) begin
                    action_phase_next = dbpc_pkg::PH_PRESSED;
                    action_ticks_next = '0;
                    fast_state_next   = 1'b1;
                    led_state_next    = 1'b0;
                end else begin
                    action_ticks_next = action_inc;
                    if (action_over || action_phase == dbpc_pkg::PH_LONG) begin
                        action_phase_next = dbpc_pkg::PH_LONG;
                        led_state_next    = action_inc[0];
                    end
                end
            end else if (action_phase != dbpc_pkg::PH_IDLE) begin
                event_next        = (action_phase == dbpc_pkg::PH_LONG) ?
                                    dbpc_pkg::EV_LONG : dbpc_pkg::EV_SHORT;
                action_phase_next = dbpc_pkg::PH_IDLE;
                action_ticks_next = '0;
                led_state_next    = 1'b1;
                fast_state_next   = 1'b0;
            end
        end
    end

endmodule

FILE: sv/dual_button_press_classifier.sv
`timescale 1ns / 1ps
// Channel  | Handshake        | Payload
// s_       | s_valid/s_ready  | s_reset_level, s_action_level
// m_       | m_valid/m_ready  | m_event_code, m_led_on, m_fast_tick,
//          |                  | m_reset_phase_out, m_action_phase_out
// cfg_     | cfg_wr_en        | cfg_index, cfg_wdata
//
// One item per cycle unless stalled; results show the cycle after intake.
// The button state and the result register update together on acceptance,
// so the state registers drive the result fields directly.
// s_ready is high whenever the result register is empty or being taken.
// Synchronous active-low reset: phases idle, counters zero, LED on.

module dual_button_press_classifier #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dbpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_reset_level,
    input  logic                                s_action_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_event_code,
    output logic                                m_led_on,
    output logic                                m_fast_tick,
    output logic [1:0]                          m_reset_phase_out,
    output logic [1:0]                          m_action_phase_out
);

    dbpc_pkg::cfg_t              cfg;
    dbpc_pkg::phase_t            reset_phase_reg,  reset_phase_next;
    dbpc_pkg::phase_t            action_phase_reg, action_phase_next;
    logic [TICK_COUNT_WIDTH-1:0] reset_ticks_reg,  reset_ticks_next;
    logic [TICK_COUNT_WIDTH-1:0] action_ticks_reg, action_ticks_next;
    logic                        led_state_reg,    led_state_next;
    logic                        fast_state_reg,   fast_state_next;
    dbpc_pkg::event_t            event_reg,        event_next;
    logic                        m_valid_reg;
    logic                        accept;

    dbpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dbpc_step #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_step (
        .cfg               (cfg),
        .reset_down        (~s_reset_level),
        .action_down       (~s_action_level),
        .reset_phase       (reset_phase_reg),
        .reset_ticks       (reset_ticks_reg),
        .action_phase      (action_phase_reg),
        .action_ticks      (action_ticks_reg),
        .led_state         (led_state_reg),
        .fast_state        (fast_state_reg),
        .reset_phase_next  (reset_phase_next),
        .reset_ticks_next  (reset_ticks_next),
        .action_phase_next (action_phase_next),
        .action_ticks_next (action_ticks_next),
        .led_state_next    (led_state_next),
        .fast_state_next   (fast_state_next),
        .event_next        (event_next)
    );

    // Take a new item whenever the result slot frees up this cycle
    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;

    // Advance button state and load the result on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_phase_reg  <= dbpc_pkg::PH_IDLE;
            reset_ticks_reg  <= '0;
            action_phase_reg <= dbpc_pkg::PH_IDLE;
            action_ticks_reg <= '0;
            led_state_reg    <= 1'b1;
            fast_state_reg   <= 1'b0;
            event_reg        <= dbpc_pkg::EV_NONE;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                reset_phase_reg  <= reset_phase_next;
                reset_ticks_reg  <= reset_ticks_next;
                action_phase_reg <= action_phase_next;
                action_ticks_reg <= action_ticks_next;
                led_state_reg    <= led_state_next;
                fast_state_reg   <= fast_state_next;
                event_reg        <= event_next;
            end
            // Hold the result until taken
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_event_code       = event_reg;
    assign m_led_on           = led_state_reg;
    assign m_fast_tick        = fast_state_reg;
    assign m_reset_phase_out  = reset_phase_reg;
    assign m_action_phase_out = action_phase_reg;

endmodule

FILE: sv/dbpc_checker.sv
`timescale 1ns / 1ps

module dbpc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_event_code,
    input logic       m_led_on,
    input logic       m_fast_tick,
    input logic [1:0] m_reset_phase_out,
    input logic [1:0] m_action_phase_out
);

    // Hold a stalled result item unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_code) && $stable(m_led_on)
            && $stable(m_fast_tick) && $stable(m_reset_phase_out)
            && $stable(m_action_phase_out))
        else $error("stalled result item changed");

    // Refuse input only while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input refused without a waiting result");

    // Factory reset leaves the reset button idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_code == dbpc_pkg::EV_FACTORY |->
            m_reset_phase_out == dbpc_pkg::PH_IDLE)
        else $error("factory reset with reset button still active");

    // Action events leave the action button idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_code == dbpc_pkg::EV_SHORT || m_event_code == dbpc_pkg::EV_LONG)
            |-> m_action_phase_out == dbpc_pkg::PH_IDLE)
        else $error("action event with action button still active");

    // Request the fast tick only while some button is active
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fast_tick |->
            m_reset_phase_out != dbpc_pkg::PH_IDLE || m_action_phase_out != dbpc_pkg::PH_IDLE)
        else $error("fast tick requested with both buttons idle");

endmodule

bind dual_button_press_classifier dbpc_checker u_dbpc_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_event_code       (m_event_code),
    .m_led_on           (m_led_on),
    .m_fast_tick        (m_fast_tick),
    .m_reset_phase_out  (m_reset_phase_out),
    .m_action_phase_out (m_action_phase_out)
);

FILE: sim/dual_button_press_classifier_test.sv
`timescale 1ns / 1ps

module dual_button_press_classifier_test;

    localparam int CNT_W       = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int STALL_SPAN  = 64;

    // One report per tick, laid out as the result ports
    typedef struct packed {
        dbpc_pkg::event_t ev;
        logic             led;
        logic             fast;
        dbpc_pkg::phase_t rst_ph;
        dbpc_pkg::phase_t act_ph;
    } tick_report_t;

    logic                            aclk;
    logic                            aresetn        = 1'b0;
    logic                            cfg_wr_en      = 1'b0;
    logic [dbpc_pkg::CFG_IDX_W-1:0]  cfg_index      = dbpc_pkg::REG_RESET_LONG;
    logic [dbpc_pkg::CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic                            s_reset_level  = 1'b1;
    logic                            s_action_level = 1'b1;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic [1:0]                      m_event_code;
    logic                            m_led_on;
    logic                            m_fast_tick;
    logic [1:0]                      m_reset_phase_out;
    logic [1:0]                      m_action_phase_out;

    // Button state and settings mirrored from the block
    dbpc_pkg::phase_t                rst_ph   = dbpc_pkg::PH_IDLE;
    dbpc_pkg::phase_t                act_ph   = dbpc_pkg::PH_IDLE;
    logic [CNT_W-1:0]                rst_cnt  = '0;
    logic [CNT_W-1:0]                act_cnt  = '0;
    logic                            led      = 1'b1;
    logic                            fast     = 1'b0;
    logic [dbpc_pkg::THR_W-1:0]      rst_thr  = dbpc_pkg::RESET_LONG_DEFAULT;
    logic [dbpc_pkg::THR_W-1:0]      act_thr  = dbpc_pkg::ACTION_LONG_DEFAULT;
    logic                            act_en   = 1'b1;

    tick_report_t          pending_reports[$];
    int                    fault_count   = 0;
    int                    items_sent    = 0;
    int                    cycle_count   = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    logic                  stall_request = 1'b0;

    dual_button_press_classifier #(
        .TICK_COUNT_WIDTH(CNT_W)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_reset_level     (s_reset_level),
        .s_action_level    (s_action_level),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_code      (m_event_code),
        .m_led_on          (m_led_on),
        .m_fast_tick       (m_fast_tick),
        .m_reset_phase_out (m_reset_phase_out),
        .m_action_phase_out(m_action_phase_out)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advance the mirrored buttons by one tick and report the outcome
    function automatic tick_report_t classify_tick(input logic rst_lvl, input logic act_lvl);
        tick_report_t     rep;
        dbpc_pkg::event_t ev;
        ev = dbpc_pkg::EV_NONE;
        // reset button goes first; locked out while the action button is busy
        if (!(act_en && act_ph != dbpc_pkg::PH_IDLE)) begin
            if (!rst_lvl) begin
                if (rst_ph == dbpc_pkg::PH_IDLE) begin
                    rst_ph  = dbpc_pkg::PH_PRESSED;
                    rst_cnt = '0;
                    fast    = 1'b1;
                end else begin
                    rst_cnt = rst_cnt + CNT_W'(1);
                    if (rst_cnt > rst_thr)
                        rst_ph = dbpc_pkg::PH_LONG;
                    if (rst_ph == dbpc_pkg::PH_LONG)
                        led = ~rst_cnt[0];
                end
            end else if (rst_ph == dbpc_pkg::PH_PRESSED) begin
                rst_ph  = dbpc_pkg::PH_IDLE;
                rst_cnt = '0;
                led     = 1'b1;
                fast    = 1'b0;
            end else if (rst_ph == dbpc_pkg::PH_LONG) begin
                ev      = dbpc_pkg::EV_FACTORY;
                rst_ph  = dbpc_pkg::PH_IDLE;
                rst_cnt = '0;
                led     = 1'b0;
                fast    = 1'b0;
            end
        end
        // action button only while enabled and the reset button is idle
        if (act_en && rst_ph == dbpc_pkg::PH_IDLE) begin
            if (!act_lvl) begin
                if (act_ph == dbpc_pkg::PH_IDLE) begin
                    act_ph  = dbpc_pkg::PH_PRESSED;
                    act_cnt = '0;
                    fast    = 1'b1;
                    led     = 1'b0;
                end else begin
                    act_cnt = act_cnt + CNT_W'(1);
                    if (act_cnt > act_thr)
                        act_ph = dbpc_pkg::PH_LONG;
                    if (act_ph == dbpc_pkg::PH_LONG)
                        led = act_cnt[0];
                end
            end else if (act_ph != dbpc_pkg::PH_IDLE) begin
                ev      = (act_ph == dbpc_pkg::PH_LONG) ? dbpc_pkg::EV_LONG : dbpc_pkg::EV_SHORT;
                act_ph  = dbpc_pkg::PH_IDLE;
                act_cnt = '0;
                led     = 1'b1;
                fast    = 1'b0;
            end
        end
        rep.ev     = ev;
        rep.led    = led;
        rep.fast   = fast;
        rep.rst_ph = rst_ph;
        rep.act_ph = act_ph;
        return rep;
    endfunction

    // Offer one tick sample, hold it until taken, then log its report
    task automatic send_item(input logic rst_lvl, input logic act_lvl);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_reset_level  <= rst_lvl;
        s_action_level <= act_lvl;
        do
            @(posedge aclk);
        while (!s_ready);
        pending_reports.push_back(classify_tick(rst_lvl, act_lvl));
        items_sent++;
    endtask

    task automatic hold_levels(input logic rst_lvl, input logic act_lvl, input int n);
        repeat (n) send_item(rst_lvl, act_lvl);
    endtask

    // Stop offering and wait until every report has come back
    task automatic await_reports;
        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write all three registers back to back once the block is quiet
    task automatic configure(input logic [dbpc_pkg::THR_W-1:0] r_thr,
                             input logic [dbpc_pkg::THR_W-1:0] a_thr,
                             input logic en);
        await_reports;
        cfg_wr_en <= 1'b1;
        cfg_index <= dbpc_pkg::REG_RESET_LONG;
        cfg_wdata <= r_thr;
        @(posedge aclk);
        cfg_index <= dbpc_pkg::REG_ACTION_LONG;
        cfg_wdata <= a_thr;
        @(posedge aclk);
        cfg_index <= dbpc_pkg::REG_ACTION_ENABLE;
        cfg_wdata <= {{(dbpc_pkg::CFG_DATA_W-1){1'b0}}, en};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rst_thr   = r_thr;
        act_thr   = a_thr;
        act_en    = en;
        @(posedge aclk);
    endtask

    // Release both buttons until neither is busy
    task automatic settle_buttons;
        repeat (3)
            if (rst_ph != dbpc_pkg::PH_IDLE || (act_en && act_ph != dbpc_pkg::PH_IDLE))
                send_item(1'b1, 1'b1);
    endtask

    function automatic logic [dbpc_pkg::THR_W-1:0] pick_threshold;
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2, 3:    return dbpc_pkg::THR_W'($urandom_range(13, 65535));
            default: return dbpc_pkg::THR_W'($urandom_range(1, 12));
        endcase
    endfunction

    // Hold long enough to cross small thresholds now and then
    function automatic int hold_span(input logic [dbpc_pkg::THR_W-1:0] thr);
        return (thr > 28) ? 30 : int'(thr) + 2;
    endfunction

    // One press pattern: a clean press, an overlap, or plain noise
    task automatic press_sequence;
        int   span;
        logic other;
        other = ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                span = $urandom_range(1, hold_span(rst_thr));
                hold_levels(1'b0, other, span);
                hold_levels(1'b1, 1'b1, 1);
            end
            4, 5, 6, 7: begin
                span = $urandom_range(1, hold_span(act_thr));
                hold_levels(other, 1'b0, span);
                hold_levels(1'b1, 1'b1, 1);
            end
            8: begin
                hold_levels(other, ~other, $urandom_range(1, 6));
                hold_levels(1'b0, 1'b0, $urandom_range(1, 6));
                hold_levels(~other, other, $urandom_range(1, 6));
                hold_levels(1'b1, 1'b1, 1);
            end
            default: begin
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    task automatic random_presses(input int n);
        int target;
        int batch_end;
        target = items_sent + n;
        while (items_sent < target) begin
            settle_buttons;
            configure(pick_threshold(), pick_threshold(), $urandom_range(0, 3) != 0);
            batch_end = items_sent + 100;
            while (items_sent < batch_end && items_sent < target)
                press_sequence;
        end
    endtask

    // Reset-value thresholds: long and short presses of each button
    task automatic test_default_thresholds;
        hold_levels(1'b1, 1'b1, 2);
        hold_levels(1'b0, 1'b1, 52);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b0, 1'b1, 3);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b1, 1'b0, 32);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b1, 1'b0, 2);
        hold_levels(1'b1, 1'b1, 1);
    endtask

    // Each button ignored while the other is busy, LED blinking when long
    task automatic test_lockout;
        configure(16'd2, 16'd1, 1'b1);
        hold_levels(1'b0, 1'b0, 5);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b1, 1'b0, 1);
        hold_levels(1'b0, 1'b0, 3);
        hold_levels(1'b0, 1'b1, 1);
        hold_levels(1'b0, 1'b1, 2);
        hold_levels(1'b1, 1'b1, 1);
    endtask

    // Action handling switched off mid-press: frozen state, no lockout
    task automatic test_enable_freeze;
        configure(16'd3, 16'd3, 1'b1);
        hold_levels(1'b1, 1'b0, 2);
        configure(16'd3, 16'd3, 1'b0);
        hold_levels(1'b0, 1'b0, 2);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b0, 1'b1, 1);
        // both busy once re-enabled: nothing may move
        configure(16'd3, 16'd3, 1'b1);
        hold_levels(1'b1, 1'b1, 2);
        configure(16'd3, 16'd3, 1'b0);
        hold_levels(1'b1, 1'b1, 1);
        configure(16'd3, 16'd3, 1'b1);
        hold_levels(1'b1, 1'b1, 1);
    endtask

    // A zero threshold makes the press long on its second held tick
    task automatic test_zero_threshold;
        configure(16'd0, 16'd0, 1'b1);
        hold_levels(1'b0, 1'b1, 2);
        hold_levels(1'b1, 1'b1, 1);
        hold_levels(1'b1, 1'b0, 2);
        hold_levels(1'b1, 1'b1, 1);
    endtask

    // Receiver stalls for a long stretch while items keep coming
    task automatic test_backpressure;
        configure(16'd4, 16'd4, 1'b1);
        stall_request = 1'b1;
        repeat (40)
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        settle_buttons;
        await_reports;
    endtask

    // Receiver: random ready, or a counted hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                m_ready <= 1'b0;
                repeat (STALL_SPAN) @(posedge aclk);
                stall_request = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare every taken result against the oldest expectation
    always @(posedge aclk) begin : report_check
        tick_report_t want;
        tick_report_t got;
        logic [1:0]   want_f[5];
        logic [1:0]   got_f[5];
        string        field_name[5];
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got = tick_report_t'({m_event_code, m_led_on, m_fast_tick,
                                  m_reset_phase_out, m_action_phase_out});
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                fault_count++;
            end else begin
                want = pending_reports.pop_front();
                field_name = '{"event_code", "led_on", "fast_tick",
                               "reset_phase_out", "action_phase_out"};
                want_f = '{want.ev, {1'b0, want.led}, {1'b0, want.fast}, want.rst_ph, want.act_ph};
                got_f  = '{got.ev, {1'b0, got.led}, {1'b0, got.fast}, got.rst_ph, got.act_ph};
                for (int i = 0; i < 5; i++)
                    if (got_f[i] !== want_f[i]) begin
                        $display("%0t: %s expected %0d got %0d", $time, field_name[i],
                                 want_f[i], got_f[i]);
                        fault_count++;
                    end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Test sequence
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 17;
        recv_idle_pct = 60;
        test_default_thresholds;
        test_lockout;
        test_enable_freeze;
        test_zero_threshold;
        test_backpressure;
        random_presses(340);

        send_idle_pct = 60;
        recv_idle_pct = 17;
        random_presses(340);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_presses(340);

        await_reports;
        repeat (8) @(posedge aclk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
sv/dbpc_pkg.sv
sv/dbpc_cfg.sv
sv/dbpc_step.sv
sv/dual_button_press_classifier.sv
sv/dbpc_checker.sv
sim/dual_button_press_classifier_test.sv
